[rtl/oaht_pkg.sv]
// package: widths, codes and helpers for the open address hash table
`default_nettype none
package oaht_pkg;
  localparam int TableEntries = 64;
  localparam int SlotBits = $clog2(TableEntries);
  localparam int KeyBytes = 8;
  localparam int ValueBits = 32;
  localparam int LenBits = 4;
  localparam int CountBits = 7;
  localparam int LoadNum = 7;
  localparam int LoadDen = 10;
  // largest entry_count that still allows one more live entry
  localparam int LoadMaxCount = (TableEntries * LoadNum) / LoadDen - 1;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeLookup = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;
  // spare code, handled as a lookup
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StEmpty = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StExhausted = 3'd4;

  typedef struct packed {
    logic load;     // capture request, start hash
    logic hash_step;
    logic probe_rd; // read slot at current probe
    logic advance;  // next probe index
    logic wr_new;
    logic wr_update;
    logic wr_revive;
    logic wr_remove;
    logic take_value; // latch value of the matching slot
  } oaht_cmd_t;

  typedef struct packed {
    logic empty_key;
    logic hash_done;
    logic used;
    logic tomb;
    logic match;
    logic last_probe;
    logic load_ok;
    logic is_insert;
  } oaht_stat_t;
endpackage
`default_nettype wire

[rtl/oaht_datapath.sv]
// datapath: key shaping, serial hash, probe address, slot memory, count
`default_nettype none
module oaht_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] mode,
  input  wire logic [63:0] key_bytes,
  input  wire logic [3:0] key_length,
  input  wire logic [31:0] new_value,
  input  wire oaht_pkg::oaht_cmd_t cmd,
  output oaht_pkg::oaht_stat_t stat,
  output logic [31:0] found_value,
  output logic [6:0] live_count
);
  import oaht_pkg::*;

  logic [KeyBytes*8-1:0] key;
  logic [LenBits-1:0] klen;
  logic [LenBits-1:0] hidx;
  logic [1:0] opmode;
  logic [ValueBits-1:0] value;
  logic [SlotBits-1:0] h;
  logic [SlotBits:0] pidx;
  logic [SlotBits-1:0] slot;
  logic [CountBits-1:0] count;

  logic [KeyBytes*8-1:0] key_mem [TableEntries];
  logic [LenBits-1:0] len_mem [TableEntries];
  logic [ValueBits-1:0] val_mem [TableEntries];
  logic [TableEntries-1:0] used;
  logic [TableEntries-1:0] tomb;
  logic [KeyBytes*8-1:0] rd_key;
  logic [LenBits-1:0] rd_len;
  logic [ValueBits-1:0] rd_val;
  logic rd_used, rd_tomb;

  logic [LenBits-1:0] shp_len;
  logic [KeyBytes*8-1:0] shp_key;
  logic stop;

  always_comb begin
    shp_len = '0;
    shp_key = '0;
    stop = 1'b0;
    for (int n = 0; n < KeyBytes; n++) begin
      if (!stop && (LenBits'(n) < key_length) && (key_bytes[8*n +: 8] != 8'd0)) begin
        shp_key[8*n +: 8] = key_bytes[8*n +: 8];
        shp_len = LenBits'(n + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  // probe i+1 slot = slot + 2(i+1) since (i+1)+(i+1)^2 - i - i^2 = 2i+2
  logic [SlotBits:0] pidx_next;
  assign pidx_next = pidx + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= shp_key;
      klen <= shp_len;
      hidx <= '0;
      h <= '0;
      opmode <= mode;
      value <= new_value[ValueBits-1:0];
    end
    if (cmd.hash_step) begin
      h <= SlotBits'(({h, 5'd0}) + h + key[8*hidx[2:0] +: 8]);
      hidx <= hidx + 1'b1;
      pidx <= '0;
    end
    if (cmd.hash_step && (hidx + 1'b1 == klen)) begin
      slot <= SlotBits'(({h, 5'd0}) + h + key[8*hidx[2:0] +: 8]);
    end
    if (cmd.advance) begin
      slot <= slot + SlotBits'({pidx_next, 1'b0});
      pidx <= pidx_next;
    end
    if (cmd.probe_rd) begin
      rd_key <= key_mem[slot];
      rd_len <= len_mem[slot];
      rd_val <= val_mem[slot];
      rd_used <= used[slot];
      rd_tomb <= tomb[slot];
    end
    if (cmd.wr_new) begin
      key_mem[slot] <= key;
      len_mem[slot] <= klen;
    end
    if (cmd.wr_new || cmd.wr_update || cmd.wr_revive) val_mem[slot] <= value;
    if (cmd.wr_remove) val_mem[slot] <= '0;
    if (cmd.load) found_value <= '0;
    if (cmd.take_value) found_value <= 32'(rd_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      tomb <= '0;
      count <= '0;
    end else begin
      if (cmd.wr_new) begin
        used[slot] <= 1'b1;
        tomb[slot] <= 1'b0;
      end
      if (cmd.wr_revive) tomb[slot] <= 1'b0;
      if (cmd.wr_remove) tomb[slot] <= 1'b1;
      if (cmd.wr_new || cmd.wr_revive) count <= count + 1'b1;
      else if (cmd.wr_remove && count != '0) count <= count - 1'b1;
    end
  end

  always_comb begin
    stat.empty_key = (klen == '0);
    stat.hash_done = (hidx == klen);
    stat.used = rd_used;
    stat.tomb = rd_tomb;
    stat.match = rd_used && (rd_len == klen) && (rd_key == key);
    stat.last_probe = (pidx_next == (SlotBits+1)'(TableEntries));
    stat.load_ok = (count <= CountBits'(LoadMaxCount));
    stat.is_insert = (opmode == ModeInsert);
  end

  assign live_count = count;
endmodule
`default_nettype wire

[rtl/oaht_controller.sv]
// controller: sequences hash, probe walk, write-back and result
`default_nettype none
module oaht_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic [1:0] mode,
  input  wire oaht_pkg::oaht_stat_t stat,
  output oaht_pkg::oaht_cmd_t cmd,
  output logic busy,
  output logic res_valid,
  input  wire logic res_ready,
  output logic [2:0] status
);
  import oaht_pkg::*;

  typedef enum logic [2:0] {SIdle, SHash, SRead, SEval, SDone} state_t;
  state_t state;
  logic [1:0] op;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    cmd.hash_step = (state == SHash) && !stat.hash_done;
    cmd.probe_rd = (state == SRead);
    if (state == SEval) begin
      if (op == ModeInsert) begin
        if (!stat.used) cmd.wr_new = stat.load_ok;
        else if (stat.match) begin
          cmd.wr_update = !stat.tomb;
          cmd.wr_revive = stat.tomb && stat.load_ok;
        end else cmd.advance = !stat.last_probe;
      end else begin
        if (stat.used && !stat.tomb && stat.match) begin
          cmd.take_value = 1'b1;
          cmd.wr_remove = (op == ModeRemove);
        end else if (stat.used) cmd.advance = !stat.last_probe;
      end
    end
  end

  assign busy = (state != SIdle) || res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      res_valid <= 1'b0;
      status <= StOk;
      op <= ModeInsert;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        SIdle: if (in_fire) begin
          op <= mode;
          state <= SHash;
        end
        SHash: if (stat.empty_key) begin
          status <= StEmpty;
          res_valid <= 1'b1;
          state <= SIdle;
        end else if (stat.hash_done) state <= SRead;
        SRead: state <= SEval;
        SEval: begin
          state <= SDone;
          if (op == ModeInsert) begin
            if (!stat.used) status <= stat.load_ok ? StOk : StFull;
            else if (stat.match) status <= (stat.tomb && !stat.load_ok) ? StFull : StOk;
            else if (stat.last_probe) status <= StExhausted;
            else state <= SRead;
          end else begin
            if (stat.used && !stat.tomb && stat.match) status <= StOk;
            else if (stat.used && !stat.last_probe) state <= SRead;
            else status <= StNotFound;
          end
        end
        SDone: begin
          res_valid <= 1'b1;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/open_address_hash_table_unit.sv]
// top level: open addressing hash table with quadratic probing
`default_nettype none
// Fixed 64-slot key/value store. One request (insert, lookup or remove) is
// worked at a time: the key hash steps through the effective key bytes
// (up to 8) and then sees the end of the key, then each probe reads the
// slot memory and then compares, up to 64 probes, and the result is then
// registered; an empty key is answered from the hash state with no probe.
// The key length and the probe walk are the variable parts.
// The slot memory is a single-port array; valid and tombstone bits sit in
// flip-flops cleared by reset, so no clearing pass is needed. The result
// stays in the output register until taken; the next request can be taken
// in the cycle after the result is taken.
module open_address_hash_table_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // lsb up: key_bytes[63:0], key_length[67:64], new_value[99:68], zero pad
  input  wire logic [103:0] s_tdata,
  // mode[1:0]
  input  wire logic [1:0] s_tuser,
  output logic m_tvalid,
  input  wire logic m_tready,
  // lsb up: status[2:0], found_value[34:3], live_count[41:35], zero pad
  output logic [47:0] m_tdata
);
  import oaht_pkg::*;

  oaht_cmd_t cmd;
  oaht_stat_t stat;
  logic busy, in_fire;
  logic [2:0] status;
  logic [31:0] found_value;
  logic [6:0] live_count;

  // request accepted only when no work and no result pending
  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;

  oaht_controller u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .mode(s_tuser), .stat(stat),
    .cmd(cmd), .busy(busy), .res_valid(m_tvalid), .res_ready(m_tready),
    .status(status)
  );

  oaht_datapath u_dp (
    .clk(clk), .rst(rst), .mode(s_tuser), .key_bytes(s_tdata[63:0]),
    .key_length(s_tdata[67:64]), .new_value(s_tdata[99:68]), .cmd(cmd),
    .stat(stat), .found_value(found_value), .live_count(live_count)
  );

  assign m_tdata = {6'd0, live_count, found_value, status};
endmodule
`default_nettype wire

[tb/oaht_checker.sv]
// checker: predicts hash table responses and compares them with the block output
`timescale 1ns / 1ps
module oaht_checker
  import oaht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  input  wire logic s_tready,
  input  wire logic [103:0] s_tdata,
  input  wire logic [1:0] s_tuser,
  input  wire logic m_tvalid,
  input  wire logic m_tready,
  input  wire logic [47:0] m_tdata,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic [6:0] live_count;
    logic [31:0] found_value;
    logic [2:0] status;
  } resp_t;

  logic [63:0] tbl_key [TableEntries];
  logic [3:0] tbl_len [TableEntries];
  logic [31:0] tbl_val [TableEntries];
  logic tbl_used [TableEntries];
  logic tbl_tomb [TableEntries];
  int live;
  resp_t want_q [$];

  assign pending = want_q.size();

  function automatic bit room_for_one();
    return (live + 1) * LoadDen <= TableEntries * LoadNum;
  endfunction

  function automatic resp_t table_op(logic [1:0] mode, logic [63:0] kb, logic [3:0] kl,
                                     logic [31:0] nv);
    int n, len, h0, i, s;
    logic [63:0] k, h;
    bit done;
    resp_t r;
    len = (kl > KeyBytes) ? KeyBytes : kl;
    n = 0;
    k = '0;
    while (n < len && kb[8*n +: 8] != 8'd0) begin
      k[8*n +: 8] = kb[8*n +: 8];
      n++;
    end
    r.status = StNotFound;
    r.found_value = '0;
    if (n == 0) begin
      r.status = StEmpty;
    end else begin
      h = '0;
      for (int b = 0; b < n; b++) h = (h << 5) + h + k[8*b +: 8];
      h0 = int'(h % TableEntries);
      i = 0;
      s = h0;
      if (mode == ModeInsert) begin
        done = 0;
        while (!done && tbl_used[s]) begin
          if (tbl_len[s] == n && tbl_key[s] == k) begin
            if (tbl_tomb[s]) begin
              if (!room_for_one()) r.status = StFull;
              else begin
                tbl_tomb[s] = 0; tbl_val[s] = nv; live++; r.status = StOk;
              end
            end else begin
              tbl_val[s] = nv; r.status = StOk;
            end
            done = 1;
          end else begin
            i++;
            s = (h0 + i + i * i) % TableEntries;
            if (i >= TableEntries) begin
              r.status = StExhausted; done = 1;
            end
          end
        end
        if (!done) begin
          if (!room_for_one()) r.status = StFull;
          else begin
            tbl_used[s] = 1; tbl_tomb[s] = 0; tbl_key[s] = k; tbl_len[s] = 4'(n);
            tbl_val[s] = nv; live++; r.status = StOk;
          end
        end
      end else begin
        while (tbl_used[s]) begin
          if (!tbl_tomb[s] && tbl_len[s] == n && tbl_key[s] == k) begin
            r.found_value = tbl_val[s];
            r.status = StOk;
            if (mode == ModeRemove) begin
              tbl_val[s] = '0; tbl_tomb[s] = 1;
              if (live > 0) live--;
            end
            break;
          end
          i++;
          if (i >= TableEntries) break;
          s = (h0 + i + i * i) % TableEntries;
        end
      end
    end
    r.live_count = live[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t got, want;
    if (rst) begin
      for (int j = 0; j < TableEntries; j++) begin
        tbl_used[j] = 0;
        tbl_tomb[j] = 0;
      end
      live = 0;
      fail_count <= 0;
      want_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        want_q.push_back(table_op(s_tuser, s_tdata[63:0], s_tdata[67:64], s_tdata[99:68]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[41:0];
        if (want_q.size() == 0) begin
          $display("%0t: unexpected response %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want || m_tdata[47:42] !== 6'd0) begin
            $display("%0t: expected status %0d value %h count %0d, got status %0d value %h count %0d",
                     $time, want.status, want.found_value, want.live_count,
                     got.status, got.found_value, got.live_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_open_address_hash_table_unit.sv]
// testbench top: drives hash table requests and reports the verdict
`timescale 1ns / 1ps
module tb_open_address_hash_table_unit;
  import oaht_pkg::*;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [103:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic [47:0] m_tdata;
  int fail_count, pending;
  logic [63:0] key_pool [16];

  open_address_hash_table_unit u_top (.*);
  oaht_checker u_chk (.*);

  initial forever #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(0, 9) < 3) ? 1'b0 : (gap_len() < 5);
  end

  // valid stays high into a zero gap; the caller drops it before idling
  task automatic send_req(logic [1:0] mode, logic [63:0] kb, logic [3:0] kl, logic [31:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {4'd0, v, kl, kb};
    // ready is stable from the falling edge on, so the next rising edge accepts
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // random key of n nonzero bytes
  function automatic logic [63:0] rand_key(int n);
    logic [63:0] k;
    k = '0;
    for (int b = 0; b < n; b++) k[8*b +: 8] = $urandom_range(1, 255);
    return k;
  endfunction

  initial begin
    logic [63:0] k;
    int r, w;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed: empty keys, zero byte cut, saturated length, all modes, extremes
    send_req(ModeInsert, 64'h0, 4'd5, 32'h1);
    send_req(ModeInsert, 64'h41, 4'd0, 32'h1);
    send_req(ModeInsert, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_req(ModeLookup, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ModeInsert, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h1234_5678);
    send_req(ModeInsert, 64'h0000_0000_0042_0041, 4'd4, 32'h55);
    send_req(ModeSpare, 64'h41, 4'd1, 32'h0);
    send_req(ModeRemove, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0);
    send_req(ModeRemove, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ModeLookup, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ModeInsert, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hAAAA_5555);
    send_req(ModeRemove, 64'h7, 4'd1, 32'h0);
    // fill up to the load limit and beyond
    for (int j = 0; j < 60; j++) send_req(ModeInsert, rand_key($urandom_range(1, 8)),
                                          4'($urandom_range(1, 15)), $urandom);
    // hold off until the block has answered everything
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int j = 0; j < 16; j++) key_pool[j] = rand_key($urandom_range(1, 8));
    for (int j = 0; j < 2000; j++) begin
      r = $urandom_range(0, 99);
      w = $urandom_range(0, 15);
      if (r < 80) begin
        k = key_pool[w];
        send_req(2'($urandom_range(0, 3)), k, 4'($urandom_range(8, 15)), $urandom);
      end else begin
        k = {$urandom, $urandom};
        send_req(2'($urandom_range(0, 3)), k, 4'($urandom_range(0, 15)), $urandom);
      end
      // refresh the working set so removes make room
      if ($urandom_range(0, 49) == 0) key_pool[w] = rand_key($urandom_range(1, 8));
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_open_address_hash_table_unit: PASS");
    end else begin
      $display("tb_open_address_hash_table_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_open_address_hash_table_unit: FAIL");
    $finish;
  end
endmodule
